### sv/ebcx_pkg.sv
// Package for the 8-bit execute unit: action codes, sub-op codes, payload types.
// No dependencies.
`default_nettype none
package ebcx_pkg;
  localparam int unsigned DataW = 8;
  localparam int unsigned MemDepth = 256;
  localparam int unsigned QueueDepth = 2;

  typedef enum logic [2:0] {
    ACT_FETCH = 3'd0,
    ACT_ALU   = 3'd1,
    ACT_MOVE  = 3'd2,
    ACT_CLOAD = 3'd3,
    ACT_CALU  = 3'd4,
    ACT_HWR   = 3'd5,
    ACT_NOP   = 3'd6
  } action_t;

  typedef enum logic [1:0] {
    ALU_AND = 2'd0,
    ALU_XOR = 2'd1,
    ALU_ADD = 2'd2,
    ALU_SUB = 2'd3
  } alu_op_t;

  typedef enum logic [1:0] {
    MV_MOVE = 2'd0,
    MV_ASR  = 2'd1,
    MV_XCHG = 2'd2,
    MV_STORE = 2'd3
  } move_op_t;

  typedef enum logic [1:0] {
    CND_NZ  = 2'd0,
    CND_Z   = 2'd1,
    CND_C   = 2'd2,
    CND_ALL = 2'd3
  } cond_t;

  typedef struct packed {
    action_t    act;
    logic [1:0] sub;
    logic [1:0] ra;
    logic [1:0] rb;
    logic [7:0] haddr;
    logic [7:0] hdata;
  } cmd_t;
endpackage
`default_nettype wire

### sv/eight_bit_cpu_execute_unit.sv
// Execute unit of a tiny 8-bit machine; one result transaction per input transaction.
// An accepted input passes the command queue and the registered output stage (fetch and taken
// loads also wait for the registered RAM read). Throughput one per cycle while the output is not stalled;
// fetch and taken loads hold off the next command until their read completes.
// Reset (synchronous, rst_n low) clears registers, flags, instruction and queue; memory not.
// Depends on ebcx_pkg, ebcx_front, ebcx_back.
`default_nettype none
module eight_bit_cpu_execute_unit
  import ebcx_pkg::*;
#(
  parameter int unsigned QDepth = QueueDepth
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // action[2:0], opcode[10:3], host_address[18:11], host_data[26:19]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [39:0]      out_tdata,  // instruction, gpr0, gpr1, gpr2, program_counter
  output logic [1:0]       out_tuser   // zero_flag, carry_flag
);
  logic q_valid, q_ready;
  cmd_t q_cmd;

  ebcx_front #(.Depth(QDepth)) u_front (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_action(in_tdata[2:0]), .in_opcode(in_tdata[10:3]),
    .in_haddr(in_tdata[18:11]), .in_hdata(in_tdata[26:19]),
    .q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd)
  );

  ebcx_back u_back (
    .clk(clk), .rst_n(rst_n),
    .q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser)
  );
endmodule
`default_nettype wire

### sv/ebcx_ram.sv
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module ebcx_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic      [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule
`default_nettype wire

### sv/ebcx_front.sv
// Front end: accepts input transactions, classifies the action, feeds the command queue.
// Depends on ebcx_pkg.
`default_nettype none
module ebcx_front
  import ebcx_pkg::*;
#(
  parameter int unsigned Depth = QueueDepth
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [2:0] in_action,
  input  wire logic [7:0] in_opcode,
  input  wire logic [7:0] in_haddr,
  input  wire logic [7:0] in_hdata,
  output logic            q_valid,
  input  wire logic       q_ready,
  output cmd_t            q_cmd
);
  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;

  cmd_t q_r [Depth];
  logic [PtrW-1:0] wp_r, rp_r;
  logic [PtrW:0]   cnt_r;
  cmd_t cmd;
  logic push, pop;

  always_comb begin
    cmd.act = action_t'(in_action);
    if (in_action == 3'd6 || in_action == 3'd7) begin
      cmd.act = ACT_NOP;
    end
    cmd.sub   = in_opcode[5:4];
    cmd.ra    = in_opcode[3:2];
    cmd.rb    = in_opcode[1:0];
    cmd.haddr = in_haddr;
    cmd.hdata = in_hdata;
  end

  assign in_tready = (cnt_r != (PtrW+1)'(Depth));
  assign push = in_tvalid && in_tready;
  assign q_valid = (cnt_r != '0);
  assign pop = q_valid && q_ready;
  assign q_cmd = q_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= cmd;
    end
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= (wp_r == PtrW'(Depth-1)) ? '0 : wp_r + 1'b1;
      end
      if (pop) begin
        rp_r <= (rp_r == PtrW'(Depth-1)) ? '0 : rp_r + 1'b1;
      end
      cnt_r <= cnt_r + (PtrW+1)'(push) - (PtrW+1)'(pop);
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= (PtrW+1)'(Depth))
    else $error("queue overflow");
  assert property (@(posedge clk) disable iff (!rst_n)
    (!push && !pop) |=> $stable(cnt_r))
    else $error("queue count moved without traffic");
  assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == (PtrW+1)'(Depth)) |-> !in_tready)
    else $error("full queue still ready");
endmodule
`default_nettype wire

### sv/ebcx_back.sv
// Back end: executes queued commands against registers, flags and memory.
// Memory reads complete in the next cycle, in a second stage. Depends on ebcx_pkg, ebcx_ram.
`default_nettype none
module ebcx_back
  import ebcx_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       q_valid,
  output logic            q_ready,
  input  cmd_t            q_cmd,
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output logic [39:0]     out_tdata,
  output logic [1:0]      out_tuser
);
  logic [7:0] regs_r [4];
  logic [7:0] regs_nxt [4];
  logic       z_r, c_r, z_nxt, c_nxt;
  logic [7:0] inst_r, inst_nxt;
  // memory read stage
  logic       mv_r;
  logic       mfetch_r;
  logic       mload_r;
  logic [1:0] mrb_r;
  logic [7:0] rdata;
  logic       ov_r;
  logic [39:0] od_r;
  logic [1:0]  ou_r;
  logic stall, take;
  logic we, re;
  logic [7:0] waddr, wdata, raddr;
  logic [7:0] a, b, k, res;
  logic [8:0] v9;
  logic go, chk;

  ebcx_ram #(.Width(DataW), .Depth(MemDepth)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .re(re), .raddr(raddr), .rdata(rdata)
  );

  function automatic logic cond_f(logic [1:0] s, logic z, logic c);
    logic r;
    case (cond_t'(s))
      CND_NZ:  r = !z;
      CND_Z:   r = z;
      CND_C:   r = c;
      default: r = 1'b1;
    endcase
    return r;
  endfunction

  // stall when output stage full and not drained; also while a read is pending
  assign stall = ov_r && !out_tready;
  assign q_ready = !stall && !mv_r;
  assign take = q_valid && q_ready;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      regs_nxt[i] = regs_r[i];
    end
    z_nxt = z_r;
    c_nxt = c_r;
    inst_nxt = inst_r;
    we = 1'b0; re = 1'b0;
    waddr = '0; wdata = '0; raddr = '0;
    a = regs_r[q_cmd.ra];
    b = regs_r[q_cmd.rb];
    k = '0; res = '0; v9 = '0; go = 1'b0; chk = 1'b0;
    if (mv_r) begin
      if (mfetch_r) begin
        inst_nxt = rdata;
      end else if (mload_r) begin
        regs_nxt[mrb_r] = rdata;
        z_nxt = (rdata == 8'd0);
        c_nxt = 1'b0;
      end
    end else if (take) begin
      case (q_cmd.act)
        ACT_FETCH: begin
          re = 1'b1;
          raddr = regs_r[3];
          regs_nxt[3] = regs_r[3] + 8'd1;
        end
        ACT_ALU, ACT_CALU: begin
          k = cond_f(q_cmd.rb, z_r, c_r) ? 8'hff : 8'h00;
          if (q_cmd.act == ACT_CALU) begin
            b = k;
          end
          case (alu_op_t'(q_cmd.sub))
            ALU_AND: v9 = {1'b0, a & b};
            ALU_XOR: v9 = {1'b0, a ^ b};
            ALU_ADD: v9 = {1'b0, a} + {1'b0, b};
            default: v9 = {1'b0, a} - {1'b0, b};
          endcase
          chk = 1'b1;
          regs_nxt[q_cmd.ra] = v9[7:0];
        end
        ACT_MOVE: begin
          case (move_op_t'(q_cmd.sub))
            MV_MOVE: regs_nxt[q_cmd.ra] = b;
            MV_ASR: begin
              v9 = {b[7], b[7], b[7:1]};
              chk = 1'b1;
              regs_nxt[q_cmd.ra] = v9[7:0];
            end
            MV_XCHG: begin
              regs_nxt[q_cmd.ra] = b;
              regs_nxt[q_cmd.rb] = a;
            end
            default: begin
              we = 1'b1;
              waddr = a;
              wdata = b;
            end
          endcase
        end
        ACT_CLOAD: begin
          go = cond_f(q_cmd.sub, z_r, c_r);
          regs_nxt[q_cmd.ra] = a + 8'd1;
          re = go;
          raddr = a;
        end
        ACT_HWR: begin
          we = 1'b1;
          waddr = q_cmd.haddr;
          wdata = q_cmd.hdata;
        end
        default: ;
      endcase
      if (chk) begin
        z_nxt = (v9 == 9'd0);
        c_nxt = v9[8];
      end
    end
    res = inst_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 4; i++) begin
        regs_r[i] <= '0;
      end
      z_r <= 1'b0;
      c_r <= 1'b0;
      inst_r <= '0;
      mv_r <= 1'b0;
      mfetch_r <= 1'b0;
      mload_r <= 1'b0;
      mrb_r <= '0;
      ov_r <= 1'b0;
    end else begin
      for (int i = 0; i < 4; i++) begin
        regs_r[i] <= regs_nxt[i];
      end
      z_r <= z_nxt;
      c_r <= c_nxt;
      inst_r <= inst_nxt;
      mv_r <= take && re;
      mfetch_r <= take && (q_cmd.act == ACT_FETCH);
      mload_r <= take && (q_cmd.act == ACT_CLOAD) && go;
      mrb_r <= q_cmd.rb;
      if (mv_r || (take && !re)) begin
        ov_r <= 1'b1;
      end else if (out_tready) begin
        ov_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mv_r || (take && !re)) begin
      od_r <= {regs_nxt[3], regs_nxt[2], regs_nxt[1], regs_nxt[0], res};
      ou_r <= {c_nxt, z_nxt};
    end
  end

  assign out_tvalid = ov_r;
  assign out_tdata = od_r;
  assign out_tuser = ou_r;

  assert property (@(posedge clk) disable iff (!rst_n) mv_r |-> !take)
    else $error("command taken during memory read");
  assert property (@(posedge clk) disable iff (!rst_n) (take && re) |=> mv_r)
    else $error("read stage lost");
  assert property (@(posedge clk) disable iff (!rst_n) (we && re) |-> 1'b0)
    else $error("read and write in one cycle");
endmodule
`default_nettype wire

### test/eight_bit_cpu_execute_unit_check.sv
// Checker for the 8-bit execute unit: watches both stream channels, predicts each result
// and compares it field by field. Depends on ebcx_pkg.
`timescale 1ns / 100ps
module eight_bit_cpu_execute_unit_check
  import ebcx_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [31:0] in_tdata,   // action[2:0], opcode[10:3], host_address[18:11], host_data[26:19]
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [39:0] out_tdata,  // instruction, gpr0, gpr1, gpr2, program_counter
  input  logic [1:0]  out_tuser,  // zero_flag, carry_flag
  output int          errors,
  output int          pending
);

  typedef struct packed {
    logic [7:0] instr;
    logic       zf;
    logic       cf;
    logic [7:0] g0;
    logic [7:0] g1;
    logic [7:0] g2;
    logic [7:0] pc;
  } machine_view_t;

  logic [7:0] regs [4];
  logic [7:0] mem [256];
  logic       zf;
  logic       cf;
  logic [7:0] instr;
  machine_view_t state_q [$];

  function automatic logic [7:0] settle(input logic [8:0] v);
    cf = v[8];
    zf = (v == 9'd0);
    return v[7:0];
  endfunction

  function automatic logic cond_met(input logic [1:0] sel);
    case (sel)
      CND_NZ:  return !zf;
      CND_Z:   return zf;
      CND_C:   return cf;
      default: return 1'b1;
    endcase
  endfunction

  function automatic logic [7:0] alu_apply(input logic [1:0] sel, input logic [7:0] a,
                                           input logic [7:0] b);
    case (sel)
      ALU_AND: return settle({1'b0, a & b});
      ALU_XOR: return settle({1'b0, a ^ b});
      ALU_ADD: return settle({1'b0, a} + {1'b0, b});
      default: return settle({1'b0, a} - {1'b0, b});
    endcase
  endfunction

  task automatic execute_cmd(input logic [31:0] d);
    logic [2:0] act;
    logic [1:0] sub, ra, rb;
    logic [7:0] addr, t;
    logic       go;
    act = d[2:0];
    sub = d[8:7];
    ra  = d[6:5];
    rb  = d[4:3];
    case (act)
      ACT_FETCH: begin
        instr   = mem[regs[3]];
        regs[3] = regs[3] + 8'd1;
      end
      ACT_ALU: regs[ra] = alu_apply(sub, regs[ra], regs[rb]);
      ACT_MOVE: begin
        case (sub)
          MV_MOVE: regs[ra] = regs[rb];
          MV_ASR:  regs[ra] = settle({regs[rb][7], regs[rb][7], regs[rb][7:1]});
          MV_XCHG: begin
            t        = regs[ra];
            regs[ra] = regs[rb];
            regs[rb] = t;
          end
          default: mem[regs[ra]] = regs[rb];
        endcase
      end
      ACT_CLOAD: begin
        go       = cond_met(sub);
        addr     = regs[ra];
        regs[ra] = addr + 8'd1;
        if (go) regs[rb] = settle({1'b0, mem[addr]});
      end
      ACT_CALU: regs[ra] = alu_apply(sub, regs[ra], cond_met(rb) ? 8'hff : 8'h00);
      ACT_HWR: mem[d[18:11]] = d[26:19];
      default: ;
    endcase
    state_q.push_back('{instr, zf, cf, regs[0], regs[1], regs[2], regs[3]});
  endtask

  task automatic report(input string what, input logic [7:0] got, input logic [7:0] want);
    $display("%0t mismatch %s: got %02h expected %02h", $realtime, what, got, want);
    errors++;
  endtask

  initial begin
    errors  = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    machine_view_t e;
    if (!rst_n) begin
      for (int i = 0; i < 4; i++) regs[i] = 8'd0;
      zf    = 1'b0;
      cf    = 1'b0;
      instr = 8'd0;
      state_q.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        if (state_q.size() == 0) begin
          $display("%0t mismatch: unexpected result transaction", $realtime);
          errors++;
        end else begin
          e = state_q.pop_front();
          if (out_tdata[7:0] !== e.instr) report("instruction", out_tdata[7:0], e.instr);
          if (out_tuser[0] !== e.zf)
            report("zero_flag", 8'(out_tuser[0]), 8'(e.zf));
          if (out_tuser[1] !== e.cf)
            report("carry_flag", 8'(out_tuser[1]), 8'(e.cf));
          if (out_tdata[15:8] !== e.g0) report("gpr0", out_tdata[15:8], e.g0);
          if (out_tdata[23:16] !== e.g1) report("gpr1", out_tdata[23:16], e.g1);
          if (out_tdata[31:24] !== e.g2) report("gpr2", out_tdata[31:24], e.g2);
          if (out_tdata[39:32] !== e.pc) report("program_counter", out_tdata[39:32], e.pc);
        end
      end
      if (in_tvalid && in_tready) execute_cmd(in_tdata);
    end
    pending = state_q.size();
  end

endmodule

### test/eight_bit_cpu_execute_unit_test.sv
// Top of the execute unit testbench: clock, reset, stimulus, stalls, watchdog and verdict.
// Depends on ebcx_pkg, eight_bit_cpu_execute_unit and eight_bit_cpu_execute_unit_check.
`timescale 1ns / 100ps
module eight_bit_cpu_execute_unit_test
  import ebcx_pkg::*;
();

  localparam logic [2:0] ActSpare = 3'd7;
  localparam int RandomItems = 1720;
  localparam int StallLimit = 2000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        in_fire = 1'b0;
  logic        steady = 1'b0;
  int          errors;
  int          pending;
  int          quiet = 0;

  always #1 clk = ~clk;

  eight_bit_cpu_execute_unit i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser)
  );

  eight_bit_cpu_execute_unit_check i_check (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser),
    .errors(errors), .pending(pending)
  );

  always @(posedge clk) begin
    in_fire <= in_tvalid && in_tready;
    if (rst_n && !(in_tvalid && in_tready) && !(out_tvalid && out_tready)) begin
      quiet <= quiet + 1;
      if (quiet >= StallLimit) begin
        $display("DONE: errors detected");
        $finish;
      end
    end else begin
      quiet <= 0;
    end
  end

  always @(negedge clk) out_tready <= steady || ($urandom_range(0, 99) >= 29);

  function automatic logic [31:0] cmd(input logic [2:0] act, input logic [1:0] sub,
                                      input logic [1:0] ra, input logic [1:0] rb,
                                      input logic [7:0] haddr, input logic [7:0] hdata);
    return {5'd0, hdata, haddr, 2'b00, sub, ra, rb, act};
  endfunction

  task automatic send(input logic [31:0] d);
    while (!steady && $urandom_range(0, 99) < 29) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= d;
    do @(negedge clk); while (!in_fire);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    do @(negedge clk); while (pending != 0);
  endtask

  initial begin
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    // fill memory so that no read ever hits an unwritten byte
    for (int a = 0; a < 256; a++)
      send(cmd(ACT_HWR, 2'($urandom), 2'($urandom), 2'($urandom), 8'(a),
               a < 4 ? 8'hff : (a < 8 ? 8'h00 : 8'($urandom))));
    send(cmd(ACT_HWR, 2'd0, 2'd0, 2'd0, 8'h00, 8'h80));
    send(cmd(ACT_HWR, 2'd3, 2'd3, 2'd3, 8'hff, 8'hff));
    send(cmd(ACT_FETCH, 2'd0, 2'd0, 2'd0, 8'h00, 8'h00));
    send(cmd(ACT_CLOAD, CND_ALL, 2'd0, 2'd1, 8'h00, 8'h00));
    send(cmd(ACT_CLOAD, CND_ALL, 2'd0, 2'd0, 8'h00, 8'h00));
    send(cmd(ACT_ALU, ALU_ADD, 2'd1, 2'd1, 8'h00, 8'h00));
    send(cmd(ACT_ALU, ALU_SUB, 2'd2, 2'd1, 8'h00, 8'h00));
    send(cmd(ACT_ALU, ALU_AND, 2'd2, 2'd0, 8'h00, 8'h00));
    send(cmd(ACT_ALU, ALU_XOR, 2'd2, 2'd2, 8'h00, 8'h00));
    send(cmd(ACT_CLOAD, CND_Z, 2'd2, 2'd0, 8'h00, 8'h00));
    send(cmd(ACT_CLOAD, CND_NZ, 2'd2, 2'd1, 8'h00, 8'h00));
    send(cmd(ACT_CLOAD, CND_C, 2'd2, 2'd1, 8'h00, 8'h00));
    send(cmd(ACT_MOVE, MV_ASR, 2'd1, 2'd0, 8'h00, 8'h00));
    send(cmd(ACT_MOVE, MV_ASR, 2'd1, 2'd2, 8'h00, 8'h00));
    send(cmd(ACT_MOVE, MV_MOVE, 2'd0, 2'd1, 8'h00, 8'h00));
    send(cmd(ACT_MOVE, MV_XCHG, 2'd0, 2'd2, 8'h00, 8'h00));
    send(cmd(ACT_MOVE, MV_XCHG, 2'd1, 2'd1, 8'h00, 8'h00));
    send(cmd(ACT_MOVE, MV_STORE, 2'd0, 2'd1, 8'h00, 8'h00));
    send(cmd(ACT_CALU, ALU_ADD, 2'd1, CND_ALL, 8'h00, 8'h00));
    send(cmd(ACT_CALU, ALU_SUB, 2'd0, CND_Z, 8'h00, 8'h00));
    send(cmd(ACT_CALU, ALU_AND, 2'd2, CND_C, 8'h00, 8'h00));
    send(cmd(ACT_CALU, ALU_XOR, 2'd3, CND_NZ, 8'h00, 8'h00));
    send(cmd(ACT_MOVE, MV_MOVE, 2'd3, 2'd1, 8'h00, 8'h00));
    send(cmd(ACT_NOP, 2'd3, 2'd3, 2'd3, 8'hff, 8'hff));
    send(cmd(ActSpare, 2'd0, 2'd0, 2'd0, 8'h00, 8'h00));
    for (int n = 0; n < RandomItems; n++) begin
      steady = (n >= 600 && n < 900);
      if (n == 1200) drain();
      send({5'd0, 8'($urandom), 8'($urandom), 8'($urandom), 3'($urandom_range(0, 7))});
    end
    steady = 1'b0;
    drain();
    repeat (8) @(negedge clk);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

### eight_bit_cpu_execute_unit.f
sv/ebcx_pkg.sv
sv/ebcx_ram.sv
sv/ebcx_front.sv
sv/ebcx_back.sv
sv/eight_bit_cpu_execute_unit.sv
test/eight_bit_cpu_execute_unit_check.sv
test/eight_bit_cpu_execute_unit_test.sv
